// ===== hw/rtl/scl_pkg.sv =====
// Shared constants and types for the serial command line parser.
`default_nettype none

package scl_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int OUT_BITS           = 32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] CMD_LEN = 2'd2;

    typedef enum logic [3:0] {
        PH_CMD = 4'b0001,
        PH_P1  = 4'b0010,
        PH_P2  = 4'b0100,
        PH_ERR = 4'b1000
    } phase_t;

    // One byte handed from the input register to the parser.
    typedef struct packed {
        logic       step;
        logic [7:0] rx_byte;
    } step_t;

    typedef struct packed {
        logic                status_ok;
        logic [7:0]          cmd_first;
        logic [7:0]          cmd_second;
        logic [OUT_BITS-1:0] first_value;
        logic [OUT_BITS-1:0] second_value;
    } record_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scl_in_reg.sv =====
// Input register of the parser, holding one received byte until the parser takes it.
`default_nettype none

module scl_in_reg
    import scl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       out_free,
    output step_t           step_out
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       advance;
    logic       accept;

    assign advance  = valid_reg && out_free;
    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg <= s_tdata;
        end
    end

    assign step_out.step    = advance;
    assign step_out.rx_byte = byte_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/scl_parser.sv =====
// Parser state and the next-state logic that turns one byte into an optional record.
`default_nettype none

module scl_parser
    import scl_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire step_t step_in,
    output logic       rec_valid,
    output record_t    rec
);

    phase_t                phase_reg, phase_next;
    logic [1:0]            count_reg, count_next;
    logic [7:0]            cmd0_reg, cmd0_next;
    logic [7:0]            cmd1_reg, cmd1_next;
    logic [VALUE_BITS-1:0] mag1_reg, mag1_next;
    logic [VALUE_BITS-1:0] mag2_reg, mag2_next;
    logic                  neg1_reg, neg1_next;
    logic                  neg2_reg, neg2_next;

    logic [7:0]            c;
    logic                  line_end;
    logic                  is_digit;
    logic                  emit;
    logic                  emit_ok;
    logic [VALUE_BITS-1:0] digit_val;
    logic [VALUE_BITS-1:0] mag1_dig;
    logic [VALUE_BITS-1:0] mag2_dig;
    logic [VALUE_BITS-1:0] val1;
    logic [VALUE_BITS-1:0] val2;
    logic [OUT_BITS-1:0]   val1_out;
    logic [OUT_BITS-1:0]   val2_out;
    logic [OUT_BITS-1:0]   raw1_out;
    logic [OUT_BITS-1:0]   raw2_out;

    assign c         = step_in.rx_byte;
    assign line_end  = (c == CH_CR) || (c == CH_LF);
    assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign digit_val = VALUE_BITS'(c[3:0]);

    // Times ten is eight times plus two times; the sum wraps at the accumulator width.
    assign mag1_dig = {mag1_reg[VALUE_BITS-4:0], 3'b000}
                    + {mag1_reg[VALUE_BITS-2:0], 1'b0} + digit_val;
    assign mag2_dig = {mag2_reg[VALUE_BITS-4:0], 3'b000}
                    + {mag2_reg[VALUE_BITS-2:0], 1'b0} + digit_val;

    assign val1 = neg1_reg ? (~mag1_reg + VALUE_BITS'(1)) : mag1_reg;
    assign val2 = neg2_reg ? (~mag2_reg + VALUE_BITS'(1)) : mag2_reg;

    generate
        if (VALUE_BITS >= OUT_BITS) begin : g_cut
            assign val1_out = val1[OUT_BITS-1:0];
            assign val2_out = val2[OUT_BITS-1:0];
            assign raw1_out = mag1_reg[OUT_BITS-1:0];
            assign raw2_out = mag2_reg[OUT_BITS-1:0];
        end else begin : g_extend
            assign val1_out = {{(OUT_BITS-VALUE_BITS){val1[VALUE_BITS-1]}}, val1};
            assign val2_out = {{(OUT_BITS-VALUE_BITS){val2[VALUE_BITS-1]}}, val2};
            assign raw1_out = {{(OUT_BITS-VALUE_BITS){1'b0}}, mag1_reg};
            assign raw2_out = {{(OUT_BITS-VALUE_BITS){1'b0}}, mag2_reg};
        end
    endgenerate

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        cmd0_next  = cmd0_reg;
        cmd1_next  = cmd1_reg;
        mag1_next  = mag1_reg;
        mag2_next  = mag2_reg;
        neg1_next  = neg1_reg;
        neg2_next  = neg2_reg;
        emit       = 1'b0;
        emit_ok    = 1'b0;

        unique case (phase_reg)
            PH_CMD: begin
                // Any byte but a line end fills the command, commas and digits included.
                if (!line_end && (count_reg < CMD_LEN)) begin
                    if (count_reg[0]) begin
                        cmd1_next = c;
                    end else begin
                        cmd0_next = c;
                    end
                    count_next = count_reg + 2'd1;
                end else if (c == CH_COMMA) begin
                    phase_next = PH_P1;
                end else begin
                    phase_next = PH_ERR;
                end
            end
            PH_P1: begin
                if (is_digit) begin
                    mag1_next = mag1_dig;
                end else if (c == CH_MINUS) begin
                    neg1_next = 1'b1;
                end else if (c == CH_COMMA) begin
                    phase_next = PH_P2;
                end else begin
                    phase_next = PH_ERR;
                end
            end
            PH_P2: begin
                if (is_digit) begin
                    mag2_next = mag2_dig;
                end else if (c == CH_MINUS) begin
                    neg2_next = 1'b1;
                end else if (line_end) begin
                    emit       = 1'b1;
                    emit_ok    = 1'b1;
                    phase_next = PH_CMD;
                end else begin
                    phase_next = PH_ERR;
                end
            end
            PH_ERR: begin
                phase_next = PH_ERR;
            end
            default: begin
                phase_next = PH_CMD;
            end
        endcase

        // A line end that leaves the parser in error closes the line with a failed record.
        if ((phase_next == PH_ERR) && line_end) begin
            emit = 1'b1;
        end

        if (emit) begin
            phase_next = PH_CMD;
            count_next = 2'd0;
            cmd0_next  = 8'd0;
            cmd1_next  = 8'd0;
            mag1_next  = '0;
            mag2_next  = '0;
            neg1_next  = 1'b0;
            neg2_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CMD;
            count_reg <= 2'd0;
            cmd0_reg  <= 8'd0;
            cmd1_reg  <= 8'd0;
            mag1_reg  <= '0;
            mag2_reg  <= '0;
            neg1_reg  <= 1'b0;
            neg2_reg  <= 1'b0;
        end else if (step_in.step) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            cmd0_reg  <= cmd0_next;
            cmd1_reg  <= cmd1_next;
            mag1_reg  <= mag1_next;
            mag2_reg  <= mag2_next;
            neg1_reg  <= neg1_next;
            neg2_reg  <= neg2_next;
        end
    end

    assign rec_valid        = step_in.step && emit;
    assign rec.status_ok    = emit_ok;
    assign rec.cmd_first    = cmd0_reg;
    assign rec.cmd_second   = cmd1_reg;
    assign rec.first_value  = emit_ok ? val1_out : raw1_out;
    assign rec.second_value = emit_ok ? val2_out : raw2_out;

endmodule

`default_nettype wire

// ===== hw/rtl/serial_command_line_parser.sv =====
// Top level of the serial command line parser: input register, parser and result register.
//
// The block takes one received byte per transaction and parses lines of the form
// "CC,p1,p2" ended by CR or LF. A finished line yields one result transaction: tuser
// is 1 for a well-formed line with signed parameters, 0 for a line that ended in error,
// which then carries the unsigned magnitudes gathered so far. Bytes that end no line
// yield no result. The block takes one byte every cycle while the result is not stalled.
// An accepted byte sits in the input register, and the parser step between the input
// register and the result register writes the record. The longest path of that step
// is the times-ten shift-add on a VALUE_BITS accumulator. A stalled result holds the
// parser, and the input register takes one more byte meanwhile only if it is empty.
`default_nettype none

module serial_command_line_parser
    import scl_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [7:0] cmd_first, [15:8] cmd_second,
                                        // [47:16] first_value, [79:48] second_value
    output logic             m_tuser    // [0] status_ok
);

    step_t   step;
    logic    out_free;
    logic    rec_valid;
    record_t rec;

    logic    out_valid_reg;
    logic    out_valid_next;
    record_t out_reg;

    assign out_free = !out_valid_reg || m_tready;

    scl_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .out_free (out_free),
        .step_out (step)
    );

    scl_parser #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_in   (step),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (rec_valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_valid) begin
            out_reg <= rec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status_ok;
    assign m_tdata  = {out_reg.second_value, out_reg.first_value,
                       out_reg.cmd_second, out_reg.cmd_first};

endmodule

`default_nettype wire
